// ===== sv/psd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the PPM stream decoder.
// ----------------------------------------------------------------------------
package psd_pkg;

  // parse phases
  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAX    = 3'd3;
  localparam logic [2:0] PH_RAW    = 3'd4;
  localparam logic [2:0] PH_TEXT   = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  // magic token progress
  localparam logic [1:0] MAG_NONE = 2'd0;
  localparam logic [1:0] MAG_P    = 2'd1;
  localparam logic [1:0] MAG_P6   = 2'd2;
  localparam logic [1:0] MAG_P3   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_MAGIC     = 3'd0;
  localparam logic [2:0] ERR_NUMBER    = 3'd1;
  localparam logic [2:0] ERR_MAXVAL    = 3'd2;
  localparam logic [2:0] ERR_DIMENSION = 3'd3;
  localparam logic [2:0] ERR_PIXELS    = 3'd4;
  localparam logic [2:0] ERR_SAMPLE    = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED = 3'd6;

  // configuration register indexes
  localparam logic CFG_MAX_DIMENSION = 1'b0;
  localparam logic CFG_MAX_PIXELS    = 1'b1;

  localparam logic [14:0] MAX_DIMENSION_RESET = 15'd16384;
  localparam logic [24:0] MAX_PIXELS_RESET    = 25'd16777216;
  localparam logic [24:0] PIXEL_CAP           = 25'd22369621;
  localparam logic [7:0]  MAX_SAMPLE          = 8'd255;

  // bytes of interest
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // divider runs one quotient bit per cycle over a 16-bit dividend
  localparam logic [3:0]  DIV_LAST  = 4'd15;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic emit_div;
  } stat_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_last;
  } cmd_t;

  // parse context without the number accumulator
  typedef struct packed {
    logic [2:0]  phase;
    logic        in_comment;
    logic        tok_act;
    logic [1:0]  magic;
    logic        bin;
    logic [14:0] wid;
    logic [14:0] hgt;
    logic [7:0]  mx;
    logic [25:0] left;
  } ctx_t;

  // result of one beat before scaling
  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [2:0] code;
    logic [7:0] smp;
    logic       last;
  } res_t;

endpackage

// ===== sv/ppm_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_stream_decoder_unit
// Streaming PPM (P6/P3) header parser and sample scaler.
// ----------------------------------------------------------------------------
// One file byte arrives per beat; an end-of-file beat closes the image and
// clears the parser for the next file. A beat that yields no result keeps
// input ready high. A header or error result is valid the cycle after its
// beat is taken. A sample first runs a bit-serial divider for the rounding
// scale to 0..255, and its result is valid when the divider finishes. Input
// ready stays low while a result is built or waits and returns the cycle
// after the result is taken. A new beat is taken only after the previous
// result has been delivered.
// Limit registers are written through cfg_we_i, cfg_index_i and cfg_data_i;
// the user must write them only while the block is idle, and the block
// itself does not enforce this.
module ppm_stream_decoder_unit #(
  parameter int unsigned NUMBER_BITS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  sample_value_o,
  output logic [14:0] image_width_o,
  output logic [14:0] image_height_o,
  output logic [7:0]  max_value_o,
  output logic        is_binary_o,
  output logic        last_sample_o,
  output logic [2:0]  error_code_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  psd_pkg::cmd_t  cmd;
  psd_pkg::stat_t stat;

  // sequencing
  psd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // parser and scaler
  psd_datapath #(
    .NB (NUMBER_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .data_byte_i    (data_byte_i),
    .end_of_file_i  (end_of_file_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_kind_o  (result_kind_o),
    .sample_value_o (sample_value_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .max_value_o    (max_value_o),
    .is_binary_o    (is_binary_o),
    .last_sample_o  (last_sample_o),
    .error_code_o   (error_code_o)
  );

endmodule

// ===== sv/psd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_ctrl
// Handshake and sequencing: accept a beat, run the scaler, hold the result.
// ----------------------------------------------------------------------------
module psd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  psd_pkg::stat_t  stat_i,
  output psd_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic       in_ready_q;
  logic       out_valid_q;

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  // commands to the datapath
  always_comb begin
    cmd_o.accept   = in_valid_i & in_ready_q;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.div_last = (state_q == ST_DIV) && (cnt_q == psd_pkg::DIV_LAST);
  end

  // state, step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            if (stat_i.emit_div) begin
              state_q    <= ST_DIV;
              cnt_q      <= '0;
              in_ready_q <= 1'b0;
            end else if (stat_i.emit) begin
              state_q     <= ST_OUT;
              in_ready_q  <= 1'b0;
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == psd_pkg::DIV_LAST) begin
            state_q     <= ST_OUT;
            out_valid_q <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/psd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_datapath
// Byte parser, limit registers, sample scaler and result registers.
// ----------------------------------------------------------------------------
module psd_datapath #(
  parameter int unsigned NB = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psd_pkg::cmd_t  cmd_i,
  output psd_pkg::stat_t stat_o,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_file_i,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [24:0]    cfg_data_i,
  output logic [1:0]     result_kind_o,
  output logic [7:0]     sample_value_o,
  output logic [14:0]    image_width_o,
  output logic [14:0]    image_height_o,
  output logic [7:0]     max_value_o,
  output logic           is_binary_o,
  output logic           last_sample_o,
  output logic [2:0]     error_code_o
);

  localparam logic [NB+3:0] CAP = {4'b0, {NB{1'b1}}};

  psd_pkg::ctx_t ctx_q, ctx_d;
  logic [NB-1:0] tok_q, tok_d;
  psd_pkg::res_t res;
  logic [14:0]   max_dim_q;
  logic [24:0]   max_pix_q;
  logic [24:0]   pix_lim;

  // scaler and result registers
  logic [15:0] dvd_q;
  logic [7:0]  rem_q;
  logic [7:0]  den_q;
  logic [8:0]  rem_sh;
  logic        ge;
  logic [1:0]  kind_q;
  logic [7:0]  smp_q;
  logic [14:0] wid_q;
  logic [14:0] hgt_q;
  logic [7:0]  mx_q;
  logic        bin_q;
  logic        last_q;
  logic [2:0]  code_q;

  function automatic psd_pkg::res_t fail(input logic [2:0] code);
    psd_pkg::res_t r;
    r      = '0;
    r.emit = 1'b1;
    r.kind = psd_pkg::KIND_ERROR;
    r.code = code;
    return r;
  endfunction

  // range check and sample count update
  function automatic void give_sample(input psd_pkg::ctx_t c_in, input logic [NB-1:0] s,
                                      output psd_pkg::ctx_t c_out, output psd_pkg::res_t r);
    logic [7:0] mxe;
    c_out = c_in;
    r     = '0;
    mxe   = (c_in.mx == 8'd0) ? 8'd1 : c_in.mx;
    if (s > {{(NB-8){1'b0}}, mxe}) begin
      c_out.phase = psd_pkg::PH_ERROR;
      r           = fail(psd_pkg::ERR_SAMPLE);
    end else begin
      if (c_in.left != 26'd0) c_out.left = c_in.left - 26'd1;
      r.emit = 1'b1;
      r.kind = psd_pkg::KIND_SAMPLE;
      r.smp  = s[7:0];
      r.last = (c_out.left == 26'd0);
      if (r.last) c_out.phase = psd_pkg::PH_DONE;
    end
  endfunction

  // close the pending token
  function automatic void end_token(input psd_pkg::ctx_t c_in, input logic [NB-1:0] v,
                                    input logic [14:0] mdim, input logic [24:0] plim,
                                    output psd_pkg::ctx_t c_out, output psd_pkg::res_t r);
    logic [29:0] pixels;
    c_out         = c_in;
    c_out.tok_act = 1'b0;
    r             = '0;
    pixels        = c_in.wid * v[14:0];
    case (c_in.phase)
      psd_pkg::PH_MAGIC: begin
        if (c_in.magic == psd_pkg::MAG_P6) begin
          c_out.bin   = 1'b1;
          c_out.phase = psd_pkg::PH_WIDTH;
        end else if (c_in.magic == psd_pkg::MAG_P3) begin
          c_out.bin   = 1'b0;
          c_out.phase = psd_pkg::PH_WIDTH;
        end else begin
          c_out.phase = psd_pkg::PH_ERROR;
          r           = fail(psd_pkg::ERR_MAGIC);
        end
      end
      psd_pkg::PH_WIDTH, psd_pkg::PH_HEIGHT: begin
        if (v == '0) begin
          c_out.phase = psd_pkg::PH_ERROR;
          r           = fail(psd_pkg::ERR_NUMBER);
        end else if (v > {{(NB-15){1'b0}}, mdim}) begin
          c_out.phase = psd_pkg::PH_ERROR;
          r           = fail(psd_pkg::ERR_DIMENSION);
        end else if (c_in.phase == psd_pkg::PH_WIDTH) begin
          c_out.wid   = v[14:0];
          c_out.phase = psd_pkg::PH_HEIGHT;
        end else begin
          c_out.hgt = v[14:0];
          if (pixels > {5'b0, plim}) begin
            c_out.phase = psd_pkg::PH_ERROR;
            r           = fail(psd_pkg::ERR_PIXELS);
          end else begin
            c_out.left  = {1'b0, pixels[24:0]} + {pixels[24:0], 1'b0};
            c_out.phase = psd_pkg::PH_MAX;
          end
        end
      end
      psd_pkg::PH_MAX: begin
        if (v == '0) begin
          c_out.phase = psd_pkg::PH_ERROR;
          r           = fail(psd_pkg::ERR_NUMBER);
        end else if (v > {{(NB-8){1'b0}}, psd_pkg::MAX_SAMPLE}) begin
          c_out.phase = psd_pkg::PH_ERROR;
          r           = fail(psd_pkg::ERR_MAXVAL);
        end else begin
          c_out.mx    = v[7:0];
          c_out.phase = c_in.bin ? psd_pkg::PH_RAW : psd_pkg::PH_TEXT;
          r.emit      = 1'b1;
          r.kind      = psd_pkg::KIND_HEADER;
        end
      end
      psd_pkg::PH_TEXT: begin
        give_sample(c_in, v, c_out, r);
        c_out.tok_act = 1'b0;
      end
      default: ;
    endcase
  endfunction

  assign pix_lim = (max_pix_q > psd_pkg::PIXEL_CAP) ? psd_pkg::PIXEL_CAP : max_pix_q;

  // one beat of parsing
  always_comb begin
    psd_pkg::ctx_t c1;
    psd_pkg::res_t r1;
    logic          is_space;
    logic          done;
    logic [NB+3:0] acc;
    ctx_d    = ctx_q;
    tok_d    = tok_q;
    res      = '0;
    c1       = ctx_q;
    r1       = '0;
    done     = (ctx_q.phase == psd_pkg::PH_DONE) || (ctx_q.phase == psd_pkg::PH_ERROR);
    is_space = (data_byte_i == psd_pkg::CH_SPACE) ||
               ((data_byte_i >= psd_pkg::CH_TAB) && (data_byte_i <= psd_pkg::CH_CR));
    acc      = {1'b0, tok_q, 3'b0} + {3'b0, tok_q, 1'b0}
             + {{(NB-4){1'b0}}, data_byte_i - psd_pkg::CH_0};
    if (end_of_file_i) begin
      if (!done) begin
        if (ctx_q.tok_act) begin
          end_token(ctx_q, tok_q, max_dim_q, pix_lim, c1, r1);
        end
        if (ctx_q.tok_act && ((c1.phase == psd_pkg::PH_DONE) ||
                              (c1.phase == psd_pkg::PH_ERROR))) begin
          res = r1;
        end else begin
          res = fail(psd_pkg::ERR_TRUNCATED);
        end
      end
      ctx_d = '0;
      tok_d = '0;
    end else if (done) begin
      res = '0;
    end else if (ctx_q.in_comment) begin
      if (data_byte_i == psd_pkg::CH_LF) ctx_d.in_comment = 1'b0;
    end else if (ctx_q.phase == psd_pkg::PH_RAW) begin
      give_sample(ctx_q, {{(NB-8){1'b0}}, data_byte_i}, ctx_d, res);
    end else if (is_space || (data_byte_i == psd_pkg::CH_HASH)) begin
      if (ctx_q.tok_act) begin
        end_token(ctx_q, tok_q, max_dim_q, pix_lim, ctx_d, res);
        tok_d = '0;
      end
      if (data_byte_i == psd_pkg::CH_HASH) ctx_d.in_comment = 1'b1;
    end else begin
      ctx_d.tok_act = 1'b1;
      if (ctx_q.phase == psd_pkg::PH_MAGIC) begin
        if ((ctx_q.magic == psd_pkg::MAG_NONE) && (data_byte_i == psd_pkg::CH_P)) begin
          ctx_d.magic = psd_pkg::MAG_P;
        end else if ((ctx_q.magic == psd_pkg::MAG_P) && (data_byte_i == psd_pkg::CH_6)) begin
          ctx_d.magic = psd_pkg::MAG_P6;
        end else if ((ctx_q.magic == psd_pkg::MAG_P) && (data_byte_i == psd_pkg::CH_3)) begin
          ctx_d.magic = psd_pkg::MAG_P3;
        end else begin
          ctx_d.phase = psd_pkg::PH_ERROR;
          res         = fail(psd_pkg::ERR_MAGIC);
        end
      end else if ((data_byte_i < psd_pkg::CH_0) || (data_byte_i > psd_pkg::CH_9)) begin
        ctx_d.phase = psd_pkg::PH_ERROR;
        res         = fail(psd_pkg::ERR_NUMBER);
      end else begin
        tok_d = (acc > CAP) ? CAP[NB-1:0] : acc[NB-1:0];
      end
    end
  end

  always_comb begin
    stat_o.emit     = res.emit;
    stat_o.emit_div = res.emit && (res.kind == psd_pkg::KIND_SAMPLE);
  end

  // parse state and limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q     <= '0;
      tok_q     <= '0;
      max_dim_q <= psd_pkg::MAX_DIMENSION_RESET;
      max_pix_q <= psd_pkg::MAX_PIXELS_RESET;
    end else begin
      if (cmd_i.accept) begin
        ctx_q <= ctx_d;
        tok_q <= tok_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          psd_pkg::CFG_MAX_DIMENSION: max_dim_q <= cfg_data_i[14:0];
          psd_pkg::CFG_MAX_PIXELS:    max_pix_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // restoring divider step: one quotient bit per cycle
  assign rem_sh = {rem_q, dvd_q[15]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  // scaler and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && res.emit) begin
      kind_q <= res.kind;
      code_q <= res.code;
      last_q <= res.last;
      smp_q  <= '0;
      if (res.kind == psd_pkg::KIND_HEADER) begin
        wid_q <= ctx_d.wid;
        hgt_q <= ctx_d.hgt;
        mx_q  <= ctx_d.mx;
        bin_q <= ctx_d.bin;
      end else begin
        wid_q <= '0;
        hgt_q <= '0;
        mx_q  <= '0;
        bin_q <= 1'b0;
      end
      // s*255 + max/2 over max
      den_q <= (ctx_q.mx == 8'd0) ? 8'd1 : ctx_q.mx;
      dvd_q <= {res.smp, 8'b0} - {8'b0, res.smp}
             + {8'b0, ((ctx_q.mx == 8'd0) ? 8'd1 : ctx_q.mx) >> 1};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 8'(rem_sh - {1'b0, den_q}) : rem_sh[7:0];
      dvd_q <= {dvd_q[14:0], ge};
      if (cmd_i.div_last) smp_q <= {dvd_q[6:0], ge};
    end
  end

  assign result_kind_o  = kind_q;
  assign sample_value_o = smp_q;
  assign image_width_o  = wid_q;
  assign image_height_o = hgt_q;
  assign max_value_o    = mx_q;
  assign is_binary_o    = bin_q;
  assign last_sample_o  = last_q;
  assign error_code_o   = code_q;

endmodule

// ===== sim/psd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Predicts and checks the results of the PPM stream decoder.
// ----------------------------------------------------------------------------
// Watches the input, output and register write ports, keeps its own copy of
// the parse state, queues the expected result of every accepted input beat
// that yields one and compares each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module psd_checker
  import psd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  result_kind_i,
  input  logic [7:0]  sample_value_i,
  input  logic [14:0] image_width_i,
  input  logic [14:0] image_height_i,
  input  logic [7:0]  max_value_i,
  input  logic        is_binary_i,
  input  logic        last_sample_i,
  input  logic [2:0]  error_code_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [24:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  smp;
    logic [14:0] wid;
    logic [14:0] hgt;
    logic [7:0]  mx;
    logic        bin;
    logic        last;
    logic [2:0]  code;
  } result_t;

  localparam logic [24:0] ACC_CAP = 25'h1FF_FFFF;

  result_t     expected_q[$];
  logic [14:0] lim_dim;
  logic [24:0] lim_pix;
  logic [2:0]  phase;
  logic        in_comment;
  logic        tok_act;
  logic [24:0] tok_val;
  logic [1:0]  magic;
  logic        bin;
  logic [14:0] wid;
  logic [14:0] hgt;
  logic [7:0]  mx;
  logic [25:0] left;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic void clear_parse();
    phase = PH_MAGIC; in_comment = 0; tok_act = 0; tok_val = '0;
    magic = MAG_NONE; bin = 0; wid = '0; hgt = '0; mx = '0; left = '0;
  endfunction

  function automatic result_t raise_error(logic [2:0] code);
    result_t r;
    r = '0;
    phase = PH_ERROR;
    r.kind = KIND_ERROR;
    r.code = code;
    return r;
  endfunction

  // scale a sample to 0..255 with rounding
  function automatic bit predict_sample(logic [24:0] s, output result_t r);
    longint unsigned m;
    r = '0;
    m = (mx == 0) ? 1 : mx;
    if (s > m) begin
      r = raise_error(ERR_SAMPLE);
      return 1;
    end
    if (left > 0) left--;
    r.kind = KIND_SAMPLE;
    r.last = (left == 0);
    if (r.last) phase = PH_DONE;
    r.smp = 8'((longint'(s) * 255 + m / 2) / m);
    return 1;
  endfunction

  function automatic bit close_token(output result_t r);
    logic [24:0] v;
    longint unsigned lim, pix;
    r = '0;
    v = tok_val;
    tok_act = 0;
    tok_val = '0;
    case (phase)
      PH_MAGIC: begin
        if (magic == MAG_P6) bin = 1;
        else if (magic == MAG_P3) bin = 0;
        else begin
          r = raise_error(ERR_MAGIC);
          return 1;
        end
        phase = PH_WIDTH;
        return 0;
      end
      PH_WIDTH, PH_HEIGHT: begin
        if (v == 0) begin
          r = raise_error(ERR_NUMBER);
          return 1;
        end
        if (v > lim_dim) begin
          r = raise_error(ERR_DIMENSION);
          return 1;
        end
        if (phase == PH_WIDTH) begin
          wid = v[14:0];
          phase = PH_HEIGHT;
          return 0;
        end
        hgt = v[14:0];
        lim = (lim_pix > PIXEL_CAP) ? PIXEL_CAP : lim_pix;
        pix = longint'(wid) * hgt;
        if (pix > lim) begin
          r = raise_error(ERR_PIXELS);
          return 1;
        end
        left = 26'(pix * 3);
        phase = PH_MAX;
        return 0;
      end
      PH_MAX: begin
        if (v == 0) begin
          r = raise_error(ERR_NUMBER);
          return 1;
        end
        if (v > MAX_SAMPLE) begin
          r = raise_error(ERR_MAXVAL);
          return 1;
        end
        mx = v[7:0];
        phase = bin ? PH_RAW : PH_TEXT;
        r.kind = KIND_HEADER;
        r.wid = wid; r.hgt = hgt; r.mx = mx; r.bin = bin;
        return 1;
      end
      PH_TEXT: return predict_sample(v, r);
      default: return 0;
    endcase
  endfunction

  function automatic bit decode_beat(logic [7:0] b, logic eof, output result_t r);
    bit got;
    longint unsigned acc;
    r = '0;
    if (eof) begin
      got = 0;
      if (phase != PH_DONE && phase != PH_ERROR) begin
        if (tok_act) got = close_token(r);
        if (!(got && (phase == PH_DONE || phase == PH_ERROR))) begin
          r = raise_error(ERR_TRUNCATED);
          got = 1;
        end
      end
      clear_parse();
      return got;
    end
    if (phase == PH_DONE || phase == PH_ERROR) return 0;
    if (in_comment) begin
      if (b == CH_LF) in_comment = 0;
      return 0;
    end
    if (phase == PH_RAW) return predict_sample(25'(b), r);
    if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_HASH) begin
      if (b == CH_HASH) in_comment = 1;
      if (tok_act) return close_token(r);
      return 0;
    end
    tok_act = 1;
    if (phase == PH_MAGIC) begin
      if (magic == MAG_NONE && b == CH_P) magic = MAG_P;
      else if (magic == MAG_P && b == CH_6) magic = MAG_P6;
      else if (magic == MAG_P && b == CH_3) magic = MAG_P3;
      else begin
        r = raise_error(ERR_MAGIC);
        return 1;
      end
      return 0;
    end
    if (b < CH_0 || b > CH_9) begin
      r = raise_error(ERR_NUMBER);
      return 1;
    end
    acc = longint'(tok_val) * 10 + (b - CH_0);
    tok_val = (acc > ACC_CAP) ? ACC_CAP : 25'(acc);
    return 0;
  endfunction

  // track registers, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    result_t r, got;
    if (!rst_ni) begin
      lim_dim = MAX_DIMENSION_RESET;
      lim_pix = MAX_PIXELS_RESET;
      clear_parse();
      expected_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAX_DIMENSION) lim_dim = cfg_data_i[14:0];
        else lim_pix = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        got = '{result_kind_i, sample_value_i, image_width_i, image_height_i,
                max_value_i, is_binary_i, last_sample_i, error_code_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          fails++;
        end else begin
          r = expected_q.pop_front();
          if (r != got) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, r, got);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        if (decode_beat(data_byte_i, end_of_file_i, r))
          expected_q.insert(expected_q.size(), r);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the PPM stream decoder.
// ----------------------------------------------------------------------------
// Streams directed and random PPM files (P6 and P3, well formed and broken)
// under several limit settings, with random gaps on both channels and long
// output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import psd_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_file_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [1:0]  result_kind_o;
  logic [7:0]  sample_value_o;
  logic [14:0] image_width_o;
  logic [14:0] image_height_o;
  logic [7:0]  max_value_o;
  logic        is_binary_o;
  logic        last_sample_o;
  logic [2:0]  error_code_o;
  logic        cfg_we_i = 0;
  logic        cfg_index_i = 0;
  logic [24:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          beats_sent = 0;
  int          idle_pct = 28;
  bit          hold_off = 0;
  int          quiet_cycles = 0;
  logic [7:0]  file_q[$];

  localparam int QUIET_LIMIT = 2000;

  always #1 clk_i = ~clk_i;

  ppm_stream_decoder_unit dut (.*);

  psd_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i,
    .end_of_file_i, .out_valid_i(out_valid_o), .out_ready_i,
    .result_kind_i(result_kind_o), .sample_value_i(sample_value_o),
    .image_width_i(image_width_o), .image_height_i(image_height_o),
    .max_value_i(max_value_o), .is_binary_i(is_binary_o),
    .last_sample_i(last_sample_o), .error_code_i(error_code_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  // watchdog on accepted beats and taken results
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid drops only while idling, so back to back beats keep it high
  task automatic send_beat(logic [7:0] b, logic eof);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1;
    data_byte_i   <= b;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic send_file(bit with_eof);
    while (file_q.size() > 0) send_beat(file_q.pop_front(), 0);
    if (with_eof) send_beat(8'($urandom), 1);
  endtask

  function automatic void put_byte(logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endfunction

  task automatic push_text(string s);
    foreach (s[i]) put_byte(s[i]);
  endtask

  function automatic string pick_gap();
    case ($urandom_range(7))
      0: return "\t";
      1: return "\n";
      2: return " # note\n";
      3: return "\r\n";
      4: return "\v\f ";
      default: return " ";
    endcase
  endfunction

  // build and send one file, mostly well formed with random content
  task automatic build_file();
    int w, h, m, n, kind;
    bit p6;
    string s;
    p6   = $urandom_range(1);
    w    = ($urandom_range(9) == 0) ? $urandom_range(40000) : $urandom_range(1, 4);
    h    = ($urandom_range(9) == 0) ? $urandom_range(40000) : $urandom_range(1, 3);
    m    = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(1, 255);
    kind = $urandom_range(19);
    push_text(p6 ? "P6" : "P3");
    if (kind == 0) push_text("x");
    push_text(pick_gap());
    push_text($sformatf("%0d", w)); push_text(pick_gap());
    push_text($sformatf("%0d", h)); push_text(pick_gap());
    s = $sformatf("%0d", m);
    if (kind == 1) s = {s, "+"};
    push_text(s);
    put_byte(p6 ? (($urandom_range(3) == 0) ? CH_HASH : CH_LF) : CH_SPACE);
    if (p6 && file_q[$] == CH_HASH) push_text(" c\n");
    n = (w * h * 3 < 40) ? w * h * 3 : 40;
    if (kind == 2) n = n / 2;
    for (int i = 0; i < n; i++) begin
      if (p6) put_byte(8'(($urandom_range(9) == 0) ? $urandom : $urandom_range(m)));
      else begin
        push_text($sformatf("%0d", ($urandom_range(19) == 0) ? $urandom_range(300)
                                                                 : $urandom_range(m)));
        if (i != n - 1 || $urandom_range(1)) push_text(pick_gap());
      end
    end
    if (kind == 3) for (int i = 0; i < 6; i++) put_byte(8'($urandom));
    if (kind == 4) begin
      file_q.delete();
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
    end
    send_file(1);
  endtask

  task automatic write_reg(logic idx, logic [24:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: formats, comments, extremes and every error but the pixel limit
    push_text("P6 2 1 255\n"); put_byte(8'h00); put_byte(8'hFF);
    repeat (4) put_byte(8'h80);
    send_file(1);
    push_text("#c\nP3\t1 1 # m\n7 0 3 7"); send_file(1);
    push_text("P5 "); send_file(1);
    push_text("P3 1 1 0 "); send_file(1);
    push_text("P3 1 1 256 "); send_file(1);
    push_text("P3 99999999999 "); send_file(1);
    push_text("P3 3 2 -1"); send_file(1);
    push_text("P6 1 1 9 "); put_byte(8'd10); send_file(1);
    push_text("P3 1 1 5 1 2"); send_file(1);
    send_beat(0, 1);
    wait_idle();

    // limits at their extremes
    write_reg(CFG_MAX_DIMENSION, 25'd1);
    write_reg(CFG_MAX_PIXELS, 25'd1);
    push_text("P3 2 "); send_file(1);
    push_text("P6 1 1 1\n"); push_text("\001\000\001"); send_file(1);
    wait_idle();
    write_reg(CFG_MAX_DIMENSION, 25'h7FFF);
    write_reg(CFG_MAX_PIXELS, 25'h1FF_FFFF);
    push_text("P3 32767 32767 "); send_file(1);
    push_text("P3 5000 4000 "); send_file(1);
    wait_idle();

    // random files under changing limits
    for (int phase_n = 0; phase_n < 6; phase_n++) begin
      case (phase_n)
        0: begin write_reg(CFG_MAX_DIMENSION, 25'd16384);
                 write_reg(CFG_MAX_PIXELS, 25'd16777216); end
        1: begin write_reg(CFG_MAX_DIMENSION, 25'd3);
                 write_reg(CFG_MAX_PIXELS, 25'd6); end
        2: begin write_reg(CFG_MAX_DIMENSION, 25'($urandom_range(1, 32767)));
                 write_reg(CFG_MAX_PIXELS, 25'($urandom)); end
        default: begin write_reg(CFG_MAX_DIMENSION, 25'h7FFF);
                 write_reg(CFG_MAX_PIXELS, 25'($urandom_range(1, 20))); end
      endcase
      idle_pct = (phase_n == 4) ? 0 : 28;
      while (beats_sent < 270 * (phase_n + 1)) begin
        if (phase_n == 3 && !hold_off && beats_sent > 900) begin
          fork
            begin hold_off = 1; repeat (300) @(posedge clk_i); hold_off = 0; end
          join_none
        end
        build_file();
      end
      wait_idle();
    end

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
